// ----- rtl/sorted_priority_queue_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Sorted priority queue - assertion macros
// Shared concurrent assertion forms, clocked and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("spq assertion failed");

// Next-cycle implication.
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("spq assertion failed");

`endif

// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue - package
// Sizes, codes and shared types of the queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH      = 16;
	localparam int PRIO_BITS  = 16;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int LETTER_W   = 8;
	localparam int REQ_PRIO_W = 16;
	localparam int OUT_CNT_W  = 5;
	localparam int STATUS_W   = 2;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef logic [STATUS_W-1:0] status_t;

	typedef struct packed {
		logic [LETTER_W-1:0]         letter;
		logic signed [PRIO_BITS-1:0] prio;
	} entry_t;

	// broadcast to every cell
	typedef struct packed {
		logic                        enq;
		logic                        deq;
		logic signed [PRIO_BITS-1:0] key;
		logic [LETTER_W-1:0]         letter;
	} cell_ctl_t;

endpackage

// ----- rtl/spq_if.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue - channel interfaces
// Valid/ready request and response channels.
// ----------------------------------------------------------------------------
interface spq_req_if;
	logic                                       valid;
	logic                                       ready;
	logic                                       op;
	logic [spq_pkg::LETTER_W-1:0]               letter;
	logic signed [spq_pkg::REQ_PRIO_W-1:0]      priority_req;

	modport source (output valid, op, letter, priority_req, input ready);
	modport sink   (input valid, op, letter, priority_req, output ready);
endinterface

interface spq_rsp_if;
	logic                                       valid;
	logic                                       ready;
	spq_pkg::status_t                           status;
	logic [spq_pkg::LETTER_W-1:0]               out_letter;
	logic signed [spq_pkg::REQ_PRIO_W-1:0]      out_priority;
	logic [spq_pkg::OUT_CNT_W-1:0]              entry_count;
	logic                                       is_empty;

	modport source (output valid, status, out_letter, out_priority, entry_count, is_empty,
		input ready);
	modport sink   (input valid, status, out_letter, out_priority, entry_count, is_empty,
		output ready);
endinterface

// ----- rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue - storage cell
// Holds one entry; on enqueue keeps, shifts right or takes the new entry,
// on dequeue takes its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  logic               occ,
	input  logic               left_lt,
	input  spq_pkg::entry_t    left_entry,
	input  spq_pkg::entry_t    right_entry,
	output logic               lt,
	output spq_pkg::entry_t    entry
);
	import spq_pkg::*;

	entry_t entry_q;

	// occupied and strictly below the key: entry stays put
	assign lt    = occ && ($signed(entry_q.prio) < $signed(ctl.key));
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.enq && !lt) begin
			if (left_lt) begin
				entry_q.letter <= ctl.letter;
				entry_q.prio   <= ctl.key;
			end else begin
				entry_q <= left_entry;
			end
		end else if (ctl.deq) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ----- rtl/sorted_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue - top level
// Insertion-sorted queue built from a row of cells; one result per request.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  --------+-----+------------------------------------------------------
//  req     | in  | op, letter, priority_req
//  rsp     | out | status, out_letter, out_priority, entry_count, is_empty
//
//  One request per cycle while req.ready is high; the cell row compares
//  and shifts, and the result enters the output register, at acceptance.
//  req.ready drops only while a result is held and rsp.ready is low.
//  Reset clears the entry count and the output valid; entry storage is
//  not cleared, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_unit_defines.svh"

module sorted_priority_queue_unit (
	input  logic  clk,
	input  logic  arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);
	import spq_pkg::*;

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [CNT_W-1:0] count_q;
	logic             out_v_q;
	status_t          status_q;
	logic [LETTER_W-1:0]          letter_q;
	logic signed [REQ_PRIO_W-1:0] prio_q;
	logic [CNT_W-1:0]             cnt_out_q;

	logic       accept;
	logic       is_full;
	logic       is_emp;
	cell_ctl_t  ctl;
	logic [DEPTH-1:0] occ;
	logic [DEPTH-1:0] lt;
	entry_t     entries [DEPTH];

	status_t          status_d;
	logic [CNT_W-1:0] count_d;

	assign req.ready = !out_v_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign is_full   = (count_q == FULL_CNT);
	assign is_emp    = (count_q == '0);

	// key is the low PRIO_BITS of the request, two's complement
	assign ctl.enq    = accept && (req.op == OP_ENQ) && !is_full;
	assign ctl.deq    = accept && (req.op == OP_DEQ) && !is_emp;
	assign ctl.key    = PRIO_BITS'($unsigned(req.priority_req));
	assign ctl.letter = req.letter;

	// cell row: occupancy from the count, neighbors chained both ways
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign occ[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			spq_cell u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.occ         (occ[i]),
				.left_lt     (1'b1),
				.left_entry  (entries[i]),
				.right_entry (entries[(i + 1) % DEPTH]),
				.lt          (lt[i]),
				.entry       (entries[i])
			);
		end else if (i == DEPTH - 1) begin : g_tail
			spq_cell u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.occ         (occ[i]),
				.left_lt     (lt[i - 1]),
				.left_entry  (entries[i - 1]),
				.right_entry (entries[i]),
				.lt          (lt[i]),
				.entry       (entries[i])
			);
		end else begin : g_mid
			spq_cell u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.occ         (occ[i]),
				.left_lt     (lt[i - 1]),
				.left_entry  (entries[i - 1]),
				.right_entry (entries[i + 1]),
				.lt          (lt[i]),
				.entry       (entries[i])
			);
		end
	end

	// status and next count
	always_comb begin
		status_d = ST_DONE;
		count_d  = count_q;
		unique case (req.op)
			OP_ENQ: begin
				if (is_full) status_d = ST_FULL;
				else         count_d  = count_q + CNT_W'(1);
			end
			OP_DEQ: begin
				if (is_emp) status_d = ST_EMPTY;
				else        count_d  = count_q - CNT_W'(1);
			end
			default: status_d = ST_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// result payload: head entry only on a real dequeue
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= status_d;
			cnt_out_q <= count_d;
			if (ctl.deq) begin
				letter_q <= entries[0].letter;
				prio_q   <= REQ_PRIO_W'($signed(entries[0].prio));
			end else begin
				letter_q <= '0;
				prio_q   <= '0;
			end
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.status       = status_q;
	assign rsp.out_letter   = letter_q;
	assign rsp.out_priority = prio_q;
	assign rsp.entry_count  = OUT_CNT_W'(cnt_out_q);
	assign rsp.is_empty     = (cnt_out_q == '0);

	`SPQ_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, count_q <= FULL_CNT)
	`SPQ_ASSERT_NXT(a_enq_grows, clk, arst_n, ctl.enq, count_q == $past(count_q) + CNT_W'(1))
	`SPQ_ASSERT_IMP(a_full_cnt, clk, arst_n, out_v_q && status_q == ST_FULL, cnt_out_q == FULL_CNT)
	`SPQ_ASSERT_IMP(a_head_sorted, clk, arst_n, count_q >= CNT_W'(2),
		$signed(entries[0].prio) <= $signed(entries[1].prio))
	`SPQ_ASSERT_NXT(a_hold_stall, clk, arst_n, out_v_q && !rsp.ready, out_v_q && $stable(status_q))

endmodule

// ----- tb/sorted_priority_queue_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue - testbench
// Drives enqueue/dequeue requests through the request channel and checks
// every result against a shadow copy of the sorted entry array kept in the
// bench. Both channels stall at random; the run ends on a clean drain.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit_test;
	import spq_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int RAND_REQS   = 1725;

	typedef struct packed {
		logic                           op;
		logic [LETTER_W-1:0]            letter;
		logic signed [REQ_PRIO_W-1:0]   prio;
	} queue_req_t;

	typedef struct packed {
		status_t                        status;
		logic [LETTER_W-1:0]            letter;
		logic signed [REQ_PRIO_W-1:0]   prio;
		logic [OUT_CNT_W-1:0]           count;
		logic                           empty;
	} queue_rsp_t;

	logic clk;
	logic arst_n;

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	sorted_priority_queue_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the queue: entries [0, shadow_count) sorted by priority,
	// head (lowest priority) at index 0.
	logic [LETTER_W-1:0]          shadow_letter [DEPTH];
	logic signed [PRIO_BITS-1:0]  shadow_prio   [DEPTH];
	int                           shadow_count;

	queue_req_t req_backlog [$];   // requests not yet offered to the block
	queue_rsp_t results_due [$];   // predicted results, oldest first

	int  fail_count;
	int  cycle_count;
	bit  req_taken;    // current request was accepted at the last rising edge
	int  req_gap;      // remaining idle cycles on the request side
	int  rsp_gap;      // remaining stall cycles on the response side
	bit  long_hold;    // long response stall, to back the block up
	bit  rand_phase;
	bit  calm;         // tail of the run: no idling on either side

	// Clock, 12 ns period.
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Apply one accepted request to the shadow queue and return the result
	// the block must produce for it.
	function automatic queue_rsp_t shadow_queue_update(queue_req_t rq);
		queue_rsp_t r;
		int         pos;
		int         i;
		r        = '0;
		r.status = ST_DONE;
		if (rq.op == OP_ENQ) begin
			if (shadow_count >= DEPTH) begin
				// full: rejected, queue untouched
				r.status = ST_FULL;
			end else begin
				// insert before the first entry with equal or greater priority,
				// so the newest of equal priorities sits closest to the head
				pos = 0;
				while (pos < shadow_count && shadow_prio[pos] < rq.prio)
					pos++;
				for (i = shadow_count; i > pos; i--) begin
					shadow_letter[i] = shadow_letter[i-1];
					shadow_prio[i]   = shadow_prio[i-1];
				end
				shadow_letter[pos] = rq.letter;
				shadow_prio[pos]   = rq.prio;
				shadow_count++;
			end
		end else begin
			if (shadow_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.letter = shadow_letter[0];
				r.prio   = shadow_prio[0];
				// only stored entries shift down
				for (i = 0; i + 1 < shadow_count; i++) begin
					shadow_letter[i] = shadow_letter[i+1];
					shadow_prio[i]   = shadow_prio[i+1];
				end
				shadow_count--;
			end
		end
		r.count = shadow_count[OUT_CNT_W-1:0];
		r.empty = (shadow_count == 0);
		return r;
	endfunction

	task automatic push_req(input logic op, input logic [LETTER_W-1:0] letter,
		input logic signed [REQ_PRIO_W-1:0] prio);
		queue_req_t rq;
		rq.op     = op;
		rq.letter = letter;
		rq.prio   = prio;
		req_backlog.push_back(rq);
	endtask

	// Priority mix: extremes, a narrow band to force ties, and full range.
	function automatic logic signed [REQ_PRIO_W-1:0] pick_priority();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: begin
				return 16'sh8000;
			end
			1: begin
				return 16'sh7fff;
			end
			2, 3: begin
				return REQ_PRIO_W'($urandom_range(0, 6) - 3);
			end
			default: begin
				return REQ_PRIO_W'($urandom);
			end
		endcase
	endfunction

	// Idling is allowed only in the first two thirds of each repeating window,
	// so there are long stretches with both channels running flat out.
	function automatic bit idle_window();
		return !calm && (cycle_count % 600) < 400;
	endfunction

	// Request driver: changes inputs at the falling edge; holds the current
	// request until it has been taken.
	always @(negedge clk) begin
		queue_req_t nxt;
		if (arst_n && !(req_ch.valid && !req_taken)) begin
			if (req_gap > 0) begin
				req_gap--;
				req_ch.valid <= 1'b0;
			end else if (req_backlog.size() != 0 && idle_window() &&
				$urandom_range(0, 99) < 12) begin
				req_gap = $urandom_range(0, 5);
				req_ch.valid <= 1'b0;
			end else if (req_backlog.size() != 0) begin
				nxt = req_backlog.pop_front();
				req_ch.op           <= nxt.op;
				req_ch.letter       <= nxt.letter;
				req_ch.priority_req <= nxt.prio;
				req_ch.valid        <= 1'b1;
			end else begin
				req_ch.valid <= 1'b0;
			end
			req_taken = 1'b0;
		end
	end

	// Response-side stalls: random short bursts plus the one long hold.
	always @(negedge clk) begin
		logic rdy;
		rdy = 1'b1;
		if (!arst_n) begin
			rdy = 1'b0;
		end else if (long_hold) begin
			rdy = 1'b0;
		end else if (rsp_gap > 0) begin
			rsp_gap--;
			rdy = 1'b0;
		end else if (idle_window() && $urandom_range(0, 99) < 12) begin
			rsp_gap = $urandom_range(0, 5);
			rdy = 1'b0;
		end
		rsp_ch.ready <= rdy;
	end

	// Scoreboard: sampled at the rising edge. Results are checked before the
	// new request is predicted; a result never belongs to a request taken on
	// the same edge, so the order does not matter.
	always @(posedge clk) begin
		queue_rsp_t got;
		queue_rsp_t want;
		queue_req_t rq;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.status = rsp_ch.status;
				got.letter = rsp_ch.out_letter;
				got.prio   = rsp_ch.out_priority;
				got.count  = rsp_ch.entry_count;
				got.empty  = rsp_ch.is_empty;
				if (results_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: status=%0d letter=%0d prio=%0d count=%0d empty=%0d",
							got.status, got.letter, got.prio, got.count, got.empty);
				end else begin
					want = results_due.pop_front();
					if (got.status !== want.status || got.letter !== want.letter ||
						got.prio !== want.prio || got.count !== want.count ||
						got.empty !== want.empty) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected status=%0d letter=%0d prio=%0d count=%0d empty=%0d, got status=%0d letter=%0d prio=%0d count=%0d empty=%0d",
								want.status, want.letter, want.prio, want.count, want.empty,
								got.status, got.letter, got.prio, got.count, got.empty);
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				rq.op     = req_ch.op;
				rq.letter = req_ch.letter;
				rq.prio   = req_ch.priority_req;
				results_due.push_back(shadow_queue_update(rq));
				req_taken = 1'b1;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// One long response stall during the random part, while the driver keeps
	// offering requests, so the output register fills and input ready drops.
	initial begin
		wait (rand_phase);
		repeat (300) @(negedge clk);
		long_hold = 1'b1;
		repeat (90) @(negedge clk);
		long_hold = 1'b0;
	end

	// Stimulus and end of run.
	initial begin
		int total;
		int run_len;
		int enq_pct;
		int i;
		logic op;

		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.op           = OP_ENQ;
		req_ch.letter       = '0;
		req_ch.priority_req = '0;
		rsp_ch.ready        = 1'b0;
		shadow_count = 0;
		fail_count   = 0;
		cycle_count  = 0;
		req_taken    = 1'b0;
		req_gap      = 0;
		rsp_gap      = 0;
		long_hold    = 1'b0;
		rand_phase   = 1'b0;
		calm         = 1'b0;

		// --- directed part ---
		// dequeue on empty
		push_req(OP_DEQ, 8'h00, 16'sh0000);
		// priority extremes and a tie at zero: newest of the tie leaves first
		push_req(OP_ENQ, 8'hff, 16'sh7fff);
		push_req(OP_ENQ, 8'h00, 16'sh8000);
		push_req(OP_ENQ, 8'haa, 16'sh0000);
		push_req(OP_ENQ, 8'h55, 16'sh0000);
		repeat (4) push_req(OP_DEQ, 8'h00, 16'sh0000);
		// fill to DEPTH with a spread of priorities, then one rejected enqueue
		for (i = 0; i < DEPTH; i++)
			push_req(OP_ENQ, LETTER_W'(i * 17 + 1), REQ_PRIO_W'((i % 5) * 4096 - 8192));
		push_req(OP_ENQ, 8'h5a, 16'sh1234);

		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// sender pause: let every directed result come back first
		while (req_backlog.size() != 0 || (req_ch.valid && !req_taken) ||
			results_due.size() != 0)
			@(negedge clk);

		// --- random part: runs leaning toward fill, balance or drain, so the
		// queue keeps reaching both full and empty ---
		total = 0;
		while (total < RAND_REQS) begin
			case ($urandom_range(0, 2))
				0: begin
					enq_pct = 20;
				end
				1: begin
					enq_pct = 50;
				end
				default: begin
					enq_pct = 85;
				end
			endcase
			run_len = $urandom_range(10, 60);
			repeat (run_len) begin
				op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
				push_req(op, LETTER_W'($urandom), pick_priority());
				total++;
			end
		end
		rand_phase = 1'b1;

		// last stretch runs with no idling
		while (req_backlog.size() > 150)
			@(negedge clk);
		calm = 1'b1;

		while (req_backlog.size() != 0 || (req_ch.valid && !req_taken) ||
			results_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);

		if (fail_count == 0 && results_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
